// ===== hdl/pwb_pkg.sv =====
// Shared constants and types of the perspective warp unit with bilinear interpolation.
package pwb_pkg;

  // Configuration registers: eight signed Q16.24 coefficients.
  localparam int COEF_W    = 40;
  localparam int NUM_COEF  = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] COEF_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] COEF_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] COEF_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] COEF_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] COEF_E = 3'd4;
  localparam logic [CFG_IDX_W-1:0] COEF_F = 3'd5;
  localparam logic [CFG_IDX_W-1:0] COEF_G = 3'd6;
  localparam logic [CFG_IDX_W-1:0] COEF_H = 3'd7;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam int Q_ONE_SHIFT = 24;
  localparam coef_t COEF_ONE = coef_t'(64'd1 << Q_ONE_SHIFT);

  localparam coef_t COEF_RESET [NUM_COEF] = '{
    COEF_ONE, '0, '0, '0, COEF_ONE, '0, '0, '0
  };

  // Item kinds carried in s_tuser.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_WARP = 1'b1;

  // Default geometry.
  localparam int DEF_IMG_WIDTH  = 576;
  localparam int DEF_IMG_HEIGHT = 432;
  localparam int DEF_OUT_OFFSET = 100;

  // Fraction bits of the interpolation weights.
  localparam int FRAC_BITS = 16;

  // Field widths and the packing of s_tdata and m_tdata.
  localparam int SRC_ROW_W   = 9;
  localparam int SRC_COL_W   = 10;
  localparam int OUT_COORD_W = 9;
  localparam int CHAN_W      = 8;
  localparam int PIX_W       = 3 * CHAN_W;

  localparam int SRC_ROW_LO = 0;
  localparam int SRC_COL_LO = SRC_ROW_LO + SRC_ROW_W;
  localparam int RED_LO     = SRC_COL_LO + SRC_COL_W;
  localparam int GREEN_LO   = RED_LO + CHAN_W;
  localparam int BLUE_LO    = GREEN_LO + CHAN_W;
  localparam int OUT_ROW_LO = BLUE_LO + CHAN_W;
  localparam int OUT_COL_LO = OUT_ROW_LO + OUT_COORD_W;
  localparam int S_DATA_W   = 64;
  localparam int M_DATA_W   = 24;

endpackage

// ===== hdl/perspective_warp_bilinear_unit.sv =====
// Top level of the perspective warp unit: frame store, homography, divider and interpolator.
//
//  channel  | direction | transfer contents
//  ---------+-----------+-------------------------------------------------------------
//  s_*      | in        | tuser: action; tdata: src_row, src_col, red, green, blue,
//           |           | out_row, out_col
//  m_*      | out       | tuser: inside_res; tdata: res_red, res_green, res_blue
//  cfg_*    | in        | write of one coefficient register, no read-back
//
// A warp request takes one transfer per cycle while the output does not stall; it passes
// four front stages, an entry stage and one divider stage per quotient bit, four tap
// stages and the output register; the depth is set by the bit-serial divider pipeline.
// Loads are written into the frame store at the cycle they are accepted, one per cycle
// while the output does not stall; a load that follows warp requests waits until those
// requests have read the store. Reset clears only control state, not the frame store.
// A stalled output only holds the pipeline when its last stage carries a result.
module perspective_warp_bilinear_unit #(
  parameter int IMG_WIDTH  = pwb_pkg::DEF_IMG_WIDTH,
  parameter int IMG_HEIGHT = pwb_pkg::DEF_IMG_HEIGHT,
  parameter int OUT_OFFSET = pwb_pkg::DEF_OUT_OFFSET
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [8:0] src_row, [18:9] src_col, [26:19] red, [34:27] green, [42:35] blue,
  // [51:43] out_row, [60:52] out_col, [63:61] zero
  input  logic [pwb_pkg::S_DATA_W-1:0]   s_tdata,
  // [0] action
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [7:0] res_red, [15:8] res_green, [23:16] res_blue
  output logic [pwb_pkg::M_DATA_W-1:0]   m_tdata,
  // [0] inside_res
  output logic                           m_tuser,
  input  logic                           cfg_we,
  input  logic [pwb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pwb_pkg::COEF_W-1:0]     cfg_data
);
  import pwb_pkg::*;

  localparam int XW     = $clog2((1 << OUT_COORD_W) + OUT_OFFSET);
  localparam int PW     = COEF_W + XW + 1;
  localparam int NW     = PW + 2;
  localparam int IB     = $clog2((IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT);
  localparam int FB     = FRAC_BITS;
  localparam int QW     = IB + FB;
  localparam int DS     = IB + FB;
  localparam int RW     = NW + IB;
  localparam int HALF_W = (IMG_WIDTH + 1) / 2;
  localparam int HALF_H = (IMG_HEIGHT + 1) / 2;
  localparam int BD     = HALF_W * HALF_H;
  localparam int AW     = $clog2(BD);
  localparam int SW     = FB + 1;
  localparam int WW     = 2 * FB + 1;
  localparam int PCW    = WW + CHAN_W;
  localparam int SUMW   = PCW + 2;

  function automatic logic [AW-1:0] bank_addr(input logic [AW-1:0] hr,
                                              input logic [AW-1:0] hc);
    bank_addr = hr * AW'(HALF_W) + hc;
  endfunction

  // Coefficient registers.
  coef_t coef [NUM_COEF];

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= COEF_RESET;
    end else if (cfg_we) begin
      coef[cfg_index] <= coef_t'(cfg_data);
    end
  end

  // Handshake and pipeline advance.
  logic        advance;
  logic        busy;
  logic        accept;
  logic        v0, v1, v2, v3, vt, va, vm, vp;
  logic [DS:0] dv;

  assign advance  = !m_tvalid || m_tready || !vp;
  assign busy     = v0 || v1 || v2 || v3 || (|dv) || vt;
  assign s_tready = advance && ((s_tuser == ACT_WARP) || !busy);
  assign accept   = s_tvalid && s_tready;

  // Frame store write side, four banks split by row and column parity so that the
  // four bilinear taps always fall in different banks.
  logic [SRC_ROW_W-1:0] ld_row;
  logic [SRC_COL_W-1:0] ld_col;
  logic                 wr_en;
  logic [1:0]           wr_bank;
  logic [AW-1:0]        wr_addr;
  logic [PIX_W-1:0]     wr_data;

  assign ld_row  = s_tdata[SRC_ROW_LO +: SRC_ROW_W];
  assign ld_col  = s_tdata[SRC_COL_LO +: SRC_COL_W];
  assign wr_en   = accept && (s_tuser == ACT_LOAD) &&
                   (32'(ld_row) < 32'(IMG_HEIGHT)) && (32'(ld_col) < 32'(IMG_WIDTH));
  assign wr_bank = {ld_row[0], ld_col[0]};
  assign wr_addr = bank_addr(AW'(ld_row >> 1), AW'(ld_col >> 1));
  assign wr_data = {s_tdata[RED_LO +: CHAN_W], s_tdata[GREEN_LO +: CHAN_W],
                    s_tdata[BLUE_LO +: CHAN_W]};

  // Stage 0: offset coordinates.
  logic [XW-1:0] x0, y0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (advance) begin
      v0 <= accept && (s_tuser == ACT_WARP);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      x0 <= XW'(s_tdata[OUT_COL_LO +: OUT_COORD_W]) + XW'(OUT_OFFSET);
      y0 <= XW'(s_tdata[OUT_ROW_LO +: OUT_COORD_W]) + XW'(OUT_OFFSET);
    end
  end

  // Stage 1: the six coefficient products.
  logic signed [PW-1:0] pa, pb, pd, pe, pg, ph;
  logic signed [XW:0]   xs, ys;

  assign xs = $signed({1'b0, x0});
  assign ys = $signed({1'b0, y0});

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pa <= coef[COEF_A] * xs;
      pb <= coef[COEF_B] * ys;
      pd <= coef[COEF_D] * xs;
      pe <= coef[COEF_E] * ys;
      pg <= coef[COEF_G] * xs;
      ph <= coef[COEF_H] * ys;
    end
  end

  // Stage 2: numerators and projective denominator.
  logic signed [NW-1:0] nu, nv, dn;
  logic signed [NW-1:0] cc_x, cf_x, one_x;

  assign cc_x  = $signed({{(NW-COEF_W){coef[COEF_C][COEF_W-1]}}, coef[COEF_C]});
  assign cf_x  = $signed({{(NW-COEF_W){coef[COEF_F][COEF_W-1]}}, coef[COEF_F]});
  assign one_x = $signed({{(NW-COEF_W){1'b0}}, COEF_ONE});

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      nu <= $signed({{2{pa[PW-1]}}, pa}) + $signed({{2{pb[PW-1]}}, pb}) + cc_x;
      nv <= $signed({{2{pd[PW-1]}}, pd}) + $signed({{2{pe[PW-1]}}, pe}) + cf_x;
      dn <= $signed({{2{pg[PW-1]}}, pg}) + $signed({{2{ph[PW-1]}}, ph}) + one_x;
    end
  end

  // Stage 3: magnitudes and the sign tests. A zero denominator or a quotient of
  // negative sign lies outside; a zero numerator is the origin itself.
  logic [NW-1:0] um, vmag, dm;
  logic          ok3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (advance) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      um   <= nu[NW-1] ? NW'(~nu + 1'b1) : NW'(nu);
      vmag <= nv[NW-1] ? NW'(~nv + 1'b1) : NW'(nv);
      dm   <= dn[NW-1] ? NW'(~dn + 1'b1) : NW'(dn);
      ok3  <= (dn != '0) &&
              ((nu == '0) || (nu[NW-1] == dn[NW-1])) &&
              ((nv == '0) || (nv[NW-1] == dn[NW-1]));
    end
  end

  // Divider pipeline: one quotient bit per stage, integer bits first against the
  // shifted denominator, then the fraction bits by doubling the remainder.
  logic [RW-1:0] dr_u [0:DS];
  logic [RW-1:0] dr_v [0:DS];
  logic [NW-1:0] dd   [0:DS];
  logic [QW-1:0] dq_u [0:DS];
  logic [QW-1:0] dq_v [0:DS];
  logic          dok  [0:DS];
  logic          dhf_u [0:DS];
  logic          dhf_v [0:DS];
  logic [RW-1:0] dm_top;

  assign dm_top = {dm, {IB{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (advance) begin
      dv[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dr_u[0]  <= RW'(um);
      dr_v[0]  <= RW'(vmag);
      dd[0]    <= dm;
      dq_u[0]  <= '0;
      dq_v[0]  <= '0;
      dhf_u[0] <= 1'b0;
      dhf_v[0] <= 1'b0;
      // A quotient whose integer part needs more than IB bits is beyond any border.
      dok[0]   <= ok3 && (RW'(um) < dm_top) && (RW'(vmag) < dm_top);
    end
  end

  for (genvar k = 0; k < DS; k++) begin : g_div
    logic [RW-1:0] dsh;
    logic [RW-1:0] ru, rv;
    logic          bu, bv;

    if (k < IB) begin : g_int
      assign dsh = RW'(dd[k]) << (IB - 1 - k);
      assign ru  = dr_u[k];
      assign rv  = dr_v[k];
    end else begin : g_frac
      assign dsh = RW'(dd[k]);
      assign ru  = dr_u[k] << 1;
      assign rv  = dr_v[k] << 1;
    end

    assign bu = (ru >= dsh);
    assign bv = (rv >= dsh);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (advance) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        dr_u[k+1] <= bu ? (ru - dsh) : ru;
        dr_v[k+1] <= bv ? (rv - dsh) : rv;
        dq_u[k+1] <= {dq_u[k][QW-2:0], bu};
        dq_v[k+1] <= {dq_v[k][QW-2:0], bv};
        dd[k+1]   <= dd[k];
        dok[k+1]  <= dok[k];
        // The remainder after the integer bits says whether the next taps are used.
        dhf_u[k+1] <= (k == IB) ? (dr_u[k] != '0) : dhf_u[k];
        dhf_v[k+1] <= (k == IB) ? (dr_v[k] != '0) : dhf_v[k];
      end
    end
  end

  // Stage T: border test against the exact quotient; an outside point is clamped to
  // the origin so that every store address stays in range.
  logic [IB-1:0] qi_u, qi_v;
  logic          hf_u_end, hf_v_end;
  logic          in_u, in_v, in_all;
  logic [IB-1:0] tu, tv;
  logic [FB-1:0] tfu, tfv;
  logic          thfu, thfv, tin;

  assign qi_u     = dq_u[DS][QW-1:FB];
  assign qi_v     = dq_v[DS][QW-1:FB];
  assign hf_u_end = (FB == 0) ? (dr_u[DS] != '0) : dhf_u[DS];
  assign hf_v_end = (FB == 0) ? (dr_v[DS] != '0) : dhf_v[DS];
  assign in_u     = (qi_u < IB'(IMG_WIDTH - 1)) ||
                    ((qi_u == IB'(IMG_WIDTH - 1)) && !hf_u_end);
  assign in_v     = (qi_v < IB'(IMG_HEIGHT - 1)) ||
                    ((qi_v == IB'(IMG_HEIGHT - 1)) && !hf_v_end);
  assign in_all   = dok[DS] && in_u && in_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      vt <= 1'b0;
    end else if (advance) begin
      vt <= dv[DS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tin  <= in_all;
      tu   <= in_all ? qi_u : '0;
      tv   <= in_all ? qi_v : '0;
      tfu  <= in_all ? dq_u[DS][FB-1:0] : '0;
      tfv  <= in_all ? dq_v[DS][FB-1:0] : '0;
      thfu <= in_all && hf_u_end;
      thfv <= in_all && hf_v_end;
    end
  end

  // Stage A: bank addresses of the four taps and the four bilinear weights.
  logic [IB-1:0] tv1, tu1, re, ro, ce, co;
  logic [SW-1:0] su, sv, fu_x, fv_x;
  logic [AW-1:0] aaddr [4];
  logic [WW-1:0] aw00, aw10, aw01, aw11;
  logic          ain, apv, apu, ahfu, ahfv;

  assign tv1  = thfv ? (tv + 1'b1) : tv;
  assign tu1  = thfu ? (tu + 1'b1) : tu;
  assign re   = tv[0] ? tv1 : tv;
  assign ro   = tv[0] ? tv : tv1;
  assign ce   = tu[0] ? tu1 : tu;
  assign co   = tu[0] ? tu : tu1;
  assign fu_x = {1'b0, tfu};
  assign fv_x = {1'b0, tfv};
  assign su   = {1'b1, {FB{1'b0}}} - fu_x;
  assign sv   = {1'b1, {FB{1'b0}}} - fv_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (advance) begin
      va <= vt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      aaddr[0] <= bank_addr(AW'(re >> 1), AW'(ce >> 1));
      aaddr[1] <= bank_addr(AW'(re >> 1), AW'(co >> 1));
      aaddr[2] <= bank_addr(AW'(ro >> 1), AW'(ce >> 1));
      aaddr[3] <= bank_addr(AW'(ro >> 1), AW'(co >> 1));
      aw00 <= WW'(sv * su);
      aw10 <= WW'(fv_x * su);
      aw01 <= WW'(sv * fu_x);
      aw11 <= WW'(fv_x * fu_x);
      ain  <= tin;
      apv  <= tv[0];
      apu  <= tu[0];
      ahfu <= thfu;
      ahfv <= thfv;
    end
  end

  // Stage M: synchronous reads of the four banks. A load accepted at the same edge
  // is not seen, which is right since it came after this request.
  logic [PIX_W-1:0] mrd [4];
  logic [WW-1:0]    mw00, mw10, mw01, mw11;
  logic             min_r, mpv, mpu, mhfu, mhfv;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PIX_W-1:0] mem [0:BD-1];

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == 2'(b))) begin
        mem[wr_addr] <= wr_data;
      end
      if (advance) begin
        mrd[b] <= mem[aaddr[b]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (advance) begin
      vm <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mw00  <= aw00;
      mw10  <= aw10;
      mw01  <= aw01;
      mw11  <= aw11;
      min_r <= ain;
      mpv   <= apv;
      mpu   <= apu;
      mhfu  <= ahfu;
      mhfv  <= ahfv;
    end
  end

  // Stage P: bank to tap mapping, unused taps forced to zero, channel products.
  logic [PIX_W-1:0] p00, p10, p01, p11;
  logic [PCW-1:0]   pp00 [3];
  logic [PCW-1:0]   pp10 [3];
  logic [PCW-1:0]   pp01 [3];
  logic [PCW-1:0]   pp11 [3];
  logic             pin;

  assign p00 = min_r ? mrd[{mpv, mpu}] : '0;
  assign p10 = (min_r && mhfv) ? mrd[{!mpv, mpu}] : '0;
  assign p01 = (min_r && mhfu) ? mrd[{mpv, !mpu}] : '0;
  assign p11 = (min_r && mhfv && mhfu) ? mrd[{!mpv, !mpu}] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (advance) begin
      vp <= vm;
    end
  end

  // Channel 0 is red in the top byte of a stored pixel, channel 2 blue in the lowest.
  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    localparam int LO = (2 - ch) * CHAN_W;

    always_ff @(posedge clk) begin
      if (advance) begin
        pp00[ch] <= PCW'(p00[LO +: CHAN_W] * mw00);
        pp10[ch] <= PCW'(p10[LO +: CHAN_W] * mw10);
        pp01[ch] <= PCW'(p01[LO +: CHAN_W] * mw01);
        pp11[ch] <= PCW'(p11[LO +: CHAN_W] * mw11);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pin <= min_r;
    end
  end

  // Output register: weighted sums, floor by dropping the weight fraction bits.
  logic [SUMW-1:0] sum_ch [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_sum
    assign sum_ch[ch] = SUMW'(pp00[ch]) + SUMW'(pp10[ch]) +
                        SUMW'(pp01[ch]) + SUMW'(pp11[ch]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (advance && vp) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && vp) begin
      m_tdata <= {sum_ch[2][2*FB +: CHAN_W], sum_ch[1][2*FB +: CHAN_W],
                  sum_ch[0][2*FB +: CHAN_W]};
      m_tuser <= pin;
    end
  end

endmodule
